// ----- design/cse_pkg.sv -----
`timescale 1ns / 1ps

package cse_pkg;

    // Table geometry.
    localparam int NUM_SIGNALS = 16;
    localparam int IDX_W       = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
    localparam int MAX_UPDATES = 4;
    localparam int CNT_W       = $clog2(MAX_UPDATES + 1);
    localparam int INIT_COUNT  = 13;

    // Frame identifiers used by the fixed mapping.
    localparam logic [10:0] ID_520 = 11'h520;
    localparam logic [10:0] ID_524 = 11'h524;
    localparam logic [10:0] ID_530 = 11'h530;
    localparam logic [10:0] ID_531 = 11'h531;
    localparam logic [10:0] ID_534 = 11'h534;
    localparam logic [10:0] ID_536 = 11'h536;

    // Unsigned Q1.16 scales, rounded to the nearest step of 2^-16.
    localparam logic [16:0] SC_1     = 17'd65536;
    localparam logic [16:0] SC_0P1   = 17'd6554;
    localparam logic [16:0] SC_0P01  = 17'd655;
    localparam logic [16:0] SC_0P001 = 17'd66;

    typedef struct packed {
        logic        valid;
        logic [10:0] id;
        logic [2:0]  offset;
        logic [16:0] scale;
    } entry_t;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } frame_t;

    typedef struct packed {
        logic [3:0]         signal_index;
        logic signed [31:0] signal_value;
        logic               last_update;
    } update_t;

    function automatic entry_t make_entry(input logic [10:0] id, input logic [2:0] offset,
                                          input logic [16:0] scale);
        entry_t e;
        e.valid  = 1'b1;
        e.id     = id;
        e.offset = offset;
        e.scale  = scale;
        return e;
    endfunction

    localparam entry_t INIT_MAP [INIT_COUNT] = '{
        make_entry(ID_520, 3'd0, SC_1),
        make_entry(ID_520, 3'd2, SC_0P1),
        make_entry(ID_520, 3'd4, SC_0P1),
        make_entry(ID_520, 3'd6, SC_0P001),
        make_entry(ID_524, 3'd2, SC_0P001),
        make_entry(ID_530, 3'd0, SC_0P01),
        make_entry(ID_530, 3'd4, SC_0P1),
        make_entry(ID_530, 3'd6, SC_0P1),
        make_entry(ID_531, 3'd2, SC_0P1),
        make_entry(ID_531, 3'd6, SC_1),
        make_entry(ID_536, 3'd4, SC_0P1),
        make_entry(ID_536, 3'd6, SC_0P1),
        make_entry(ID_534, 3'd4, SC_1)
    };

    // Entries past the fixed mapping, or past the table size, are invalid.
    function automatic entry_t table_entry(input logic [IDX_W-1:0] idx);
        entry_t e;
        e = '0;
        for (int k = 0; k < INIT_COUNT; k++) begin
            if ((k == int'(idx)) && (k < NUM_SIGNALS)) begin
                e = INIT_MAP[k];
            end
        end
        return e;
    endfunction

endpackage

// ----- design/cse_scale_unit.sv -----
`timescale 1ns / 1ps

// Picks the little-endian word at the given offset and scales it to Q16.16.
module cse_scale_unit
    import cse_pkg::*;
(
    input  frame_t             frame,
    input  logic [2:0]         offset,
    input  logic [16:0]        scale,
    output logic signed [31:0] product
);

    logic [7:0]         bytes [8];
    logic [2:0]         hi_offset;
    logic signed [15:0] raw_word;
    logic signed [17:0] scale_s;
    logic signed [33:0] full_product;

    assign bytes[0] = frame.byte0;
    assign bytes[1] = frame.byte1;
    assign bytes[2] = frame.byte2;
    assign bytes[3] = frame.byte3;
    assign bytes[4] = frame.byte4;
    assign bytes[5] = frame.byte5;
    assign bytes[6] = frame.byte6;
    assign bytes[7] = frame.byte7;

    // The high byte wraps back to byte 0 when the offset is seven.
    assign hi_offset    = offset + 3'd1;
    assign raw_word     = {bytes[hi_offset], bytes[offset]};
    assign scale_s      = {1'b0, scale};
    assign full_product = raw_word * scale_s;
    assign product      = full_product[31:0];

endmodule

// ----- design/can_signal_extractor.sv -----
`timescale 1ns / 1ps

// Channel  | Signals                            | Direction | Payload
// ---------+------------------------------------+-----------+--------------------------------
// frame    | frame_valid, frame_stall, frame    | in        | frame_t: identifier, 8 bytes
// update   | update_valid, update_stall, update | out       | update_t: index, value, last
//
// A frame is taken only while the block is idle. The sequencer then looks at one table
// entry per cycle through the shared select-and-multiply unit, except while a new match
// waits for a stalled output register. The scan stops at the last entry or once the fourth
// match is found, and a flush state then delivers the last update if any match was found.
// No new frame is taken until the sequencer is back in idle.
// The signal table is constant logic, so reset needs no clearing pass; rst_n is
// asynchronous and active low and returns the sequencer to idle with no update pending.
module can_signal_extractor
    import cse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    frame_valid,
    output logic    frame_stall,
    input  frame_t  frame,
    output logic    update_valid,
    input  logic    update_stall,
    output update_t update
);

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SIGNALS - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    frame_t             frame_reg, frame_next;

    // The pending update holds the newest match until we know whether it is the last one.
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic signed [31:0] pend_value_reg, pend_value_next;

    logic               update_valid_reg, update_valid_next;
    update_t            update_reg, update_next;

    entry_t             entry;
    logic               hit;
    logic               out_free;
    logic               scan_done;
    logic signed [31:0] product;

    cse_scale_unit u_scale (
        .frame   (frame_reg),
        .offset  (entry.offset),
        .scale   (entry.scale),
        .product (product)
    );

    assign entry    = table_entry(idx_reg);
    assign hit      = entry.valid && (entry.id == frame_reg.frame_id);
    assign out_free = !update_valid_reg || !update_stall;

    // Scanning ends at the last table entry or when the final allowed match is taken.
    assign scan_done = (idx_reg == LAST_IDX) ||
                       (hit && (cnt_reg == CNT_W'(MAX_UPDATES - 1)));

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        frame_next        = frame_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        pend_value_next   = pend_value_reg;
        update_next       = update_reg;
        update_valid_next = update_valid_reg && update_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_next      = frame;
                    idx_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // A new match can only displace the pending one once the output is free.
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            update_next.signal_index = 4'(pend_idx_reg);
                            update_next.signal_value = pend_value_reg;
                            update_next.last_update  = 1'b0;
                            update_valid_next        = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        pend_value_next = product;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    if (scan_done)
                    begin
                        if (hit || pend_valid_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    update_next.signal_index = 4'(pend_idx_reg);
                    update_next.signal_value = pend_value_reg;
                    update_next.last_update  = 1'b1;
                    update_valid_next        = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            update_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            cnt_reg          <= cnt_next;
            pend_valid_reg   <= pend_valid_next;
            update_valid_reg <= update_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        pend_idx_reg   <= pend_idx_next;
        pend_value_reg <= pend_value_next;
        update_reg     <= update_next;
    end

    assign frame_stall  = (state_reg != ST_IDLE);
    assign update_valid = update_valid_reg;
    assign update       = update_reg;

`ifndef SYNTHESIS
    // The flush state always has a pending update to deliver.
    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("flush state without a pending update");

    // Nothing is left pending once the sequencer is back in idle.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending update left over in idle");

    // A frame transaction starts a clean scan from the top of the table.
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_stall) |=>
            ((state_reg == ST_SCAN) && (idx_reg == '0) && (cnt_reg == '0) && !pend_valid_reg))
        else $error("frame transaction did not start a clean scan");

    // No more than the allowed number of updates per frame.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_UPDATES))
        else $error("update count exceeded its limit");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for can_signal_extractor.
//
// Frames go in on the frame channel and signal updates come out on the update channel.
// A behavioral copy of the signal table, written out here from the package constants,
// predicts the updates of each random frame and of most directed rows at the moment the
// frame transaction is accepted; the other directed rows carry their updates typed in.
// The expected updates wait in a queue. Every update transaction is compared field by
// field with the oldest entry in that queue.
// The run has a short directed table first. It covers no-match identifiers, the extreme
// raw words at scale 1.0, a four-match frame, near-miss identifiers and the sign bit of
// each byte. Random frames follow in four idling phases. Most of the random frames use the
// identifiers of the fixed mapping so that the table walk and the multiplier see real
// work. The rest use arbitrary identifiers, so every identifier bit takes both values.
module tb_top;
    import cse_pkg::*;

    // Period 4 ns. Each frame takes at most one table walk plus output stalls, so the limit
    // below leaves a wide margin for about 420 frames.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 100;   // per idling phase
    localparam int NUM_PHASES   = 4;

    typedef struct {
        frame_t frm;
        int     n_typed;   // -1: the predictor supplies the expected updates
    } stim_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    frame_valid  = 1'b0;
    frame_t  frame        = '0;
    logic    update_stall = 1'b0;
    logic    frame_stall;
    logic    update_valid;
    update_t update;

    entry_t  signal_map [NUM_SIGNALS];
    update_t pending_updates [$];
    int      error_count    = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    can_signal_extractor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .update_valid (update_valid),
        .update_stall (update_stall),
        .update       (update)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The run ends here if the block hangs or drops an update.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL can_signal_extractor");
            $finish;
        end
    end

    // The printed lines are capped so that a badly broken block cannot flood the log.
    // Every mismatch still counts.
    task automatic report_mismatch(input string msg);
        if (error_count < 60)
        begin
            $display("ERROR @%0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic frame_t frame_of(input logic [10:0] id, input logic [63:0] data);
        frame_t f;
        f.frame_id = id;
        f.byte0    = data[7:0];
        f.byte1    = data[15:8];
        f.byte2    = data[23:16];
        f.byte3    = data[31:24];
        f.byte4    = data[39:32];
        f.byte5    = data[47:40];
        f.byte6    = data[55:48];
        f.byte7    = data[63:56];
        return f;
    endfunction

    // The table is walked from index 0 upward. The first MAX_UPDATES valid entries with a
    // matching identifier each give one update, and the last of them carries the flag.
    // The high byte index wraps within the eight data bytes.
    task automatic predict_updates(input frame_t f);
        logic [7:0]  data_bytes [8];
        logic [2:0]  lo_sel;
        logic [2:0]  hi_sel;
        logic [15:0] raw_word;
        longint      product;
        update_t     found [MAX_UPDATES];
        int          hits;
        data_bytes = '{f.byte0, f.byte1, f.byte2, f.byte3,
                       f.byte4, f.byte5, f.byte6, f.byte7};
        hits = 0;
        for (int i = 0; i < NUM_SIGNALS; i++)
        begin
            if (hits < MAX_UPDATES && signal_map[i].valid && signal_map[i].id == f.frame_id)
            begin
                lo_sel   = signal_map[i].offset;
                hi_sel   = lo_sel + 3'd1;
                raw_word = {data_bytes[hi_sel], data_bytes[lo_sel]};
                product  = longint'($signed(raw_word)) * longint'(signal_map[i].scale);
                found[hits].signal_index = i[3:0];
                found[hits].signal_value = product[31:0];
                found[hits].last_update  = 1'b0;
                hits++;
            end
        end
        if (hits > 0)
        begin
            found[hits - 1].last_update = 1'b1;
        end
        for (int k = 0; k < hits; k++)
        begin
            pending_updates.push_back(found[k]);
        end
    endtask

    // This task is called in the time step of a clock edge and returns in the step of the
    // edge that accepted the frame. frame_valid stays high on return, so the next call
    // either lowers it for an idle cycle or presents the next frame at once.
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        do
        begin
            @(posedge clk);
        end
        while (frame_stall);
    endtask

    // The sender stays quiet until every predicted update has been seen. It always waits for
    // a clock edge first, so the next frame is driven in a later time step.
    task automatic drain_updates();
        frame_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_updates.size() != 0);
    endtask

    // The receiver stalls at random. Outputs are sampled at the edge, before the block's
    // own registers move, so the transaction seen here is the one accepted at this edge.
    always @(posedge clk)
    begin
        update_t want;
        update_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && update_valid && !update_stall)
        begin
            if (pending_updates.size() == 0)
            begin
                report_mismatch($sformatf("unexpected update: index %0d value %0d last %0b",
                                          update.signal_index, update.signal_value,
                                          update.last_update));
            end
            else
            begin
                want = pending_updates.pop_front();
                if (update.signal_index != want.signal_index)
                begin
                    report_mismatch($sformatf("signal_index %0d, expected %0d",
                                              update.signal_index, want.signal_index));
                end
                if (update.signal_value != want.signal_value)
                begin
                    report_mismatch($sformatf("signal_value %0d at index %0d, expected %0d",
                                              update.signal_value, want.signal_index,
                                              want.signal_value));
                end
                if (update.last_update != want.last_update)
                begin
                    report_mismatch($sformatf("last_update %0b at index %0d, expected %0b",
                                              update.last_update, want.signal_index,
                                              want.last_update));
                end
            end
        end
    end

    initial
    begin
        stim_row_t   dir_rows [$];
        update_t     dir_expected [$];
        logic [10:0] known_ids [6];
        logic [7:0]  fill_byte [4];
        logic [10:0] id;
        logic [63:0] data;
        int          idle_mix [NUM_PHASES];
        int          stall_mix [NUM_PHASES];
        int          typed_pos;

        // Fixed mapping: identifier, offset of the low byte, unsigned Q1.16 scale.
        for (int i = 0; i < NUM_SIGNALS; i++)
        begin
            signal_map[i] = '0;
        end
        signal_map[0]  = '{1'b1, ID_520, 3'd0, SC_1};
        signal_map[1]  = '{1'b1, ID_520, 3'd2, SC_0P1};
        signal_map[2]  = '{1'b1, ID_520, 3'd4, SC_0P1};
        signal_map[3]  = '{1'b1, ID_520, 3'd6, SC_0P001};
        signal_map[4]  = '{1'b1, ID_524, 3'd2, SC_0P001};
        signal_map[5]  = '{1'b1, ID_530, 3'd0, SC_0P01};
        signal_map[6]  = '{1'b1, ID_530, 3'd4, SC_0P1};
        signal_map[7]  = '{1'b1, ID_530, 3'd6, SC_0P1};
        signal_map[8]  = '{1'b1, ID_531, 3'd2, SC_0P1};
        signal_map[9]  = '{1'b1, ID_531, 3'd6, SC_1};
        signal_map[10] = '{1'b1, ID_536, 3'd4, SC_0P1};
        signal_map[11] = '{1'b1, ID_536, 3'd6, SC_0P1};
        signal_map[12] = '{1'b1, ID_534, 3'd4, SC_1};

        known_ids = '{ID_520, ID_524, ID_530, ID_531, ID_534, ID_536};
        fill_byte = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        idle_mix  = '{0, 55, 0, 12};
        stall_mix = '{0, 0, 55, 12};

        // Directed table. The data word is written with byte 7 on the left, so a 16-bit
        // little-endian word at an even offset reads directly in the hex digits.
        // Rows whose updates are obvious carry them typed in below.
        dir_rows.push_back(stim_row_t'{frame_of(11'h000, 64'h0000_0000_0000_0000), 0});
        dir_rows.push_back(stim_row_t'{frame_of(11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF), 0});
        dir_rows.push_back(stim_row_t'{frame_of(ID_534,  64'h0000_7FFF_0000_0000), 1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_534,  64'h0000_8000_0000_0000), 1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_524,  64'h0000_0000_8000_0000), 1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_520,  64'h0000_0000_0000_0000), 4});
        dir_rows.push_back(stim_row_t'{frame_of(ID_520,  64'hFFFF_FFFF_FFFF_FFFF), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_520,  64'h0807_0605_0403_0201), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_520,  64'h5555_AAAA_5555_AAAA), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_530,  64'h7FFF_8000_1234_8001), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_530,  64'h8000_7FFF_FFFF_7FFF), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_531,  64'h7FFF_0000_8000_0000), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_531,  64'hFFFF_FFFF_FFFF_FFFF), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_536,  64'h8000_7FFF_0000_0000), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_536,  64'h0001_FFFF_5555_AAAA), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_524,  64'h0000_0000_7FFF_0000), -1});
        dir_rows.push_back(stim_row_t'{frame_of(ID_524,  64'hAAAA_5555_AAAA_5555), -1});
        // Identifiers one bit away from a mapped one must not match.
        dir_rows.push_back(stim_row_t'{frame_of(11'h521, 64'h0000_7FFF_0000_0000), -1});
        dir_rows.push_back(stim_row_t'{frame_of(11'h420, 64'h1111_2222_3333_4444), -1});
        dir_rows.push_back(stim_row_t'{frame_of(11'h535, 64'h7FFF_7FFF_7FFF_7FFF), -1});

        // Largest and smallest product at scale 1.0, the most negative word at 0.001,
        // and a zero frame that hits all four entries of identifier 0x520.
        dir_expected.push_back(update_t'{4'd12, 32'h7FFF_0000, 1'b1});
        dir_expected.push_back(update_t'{4'd12, 32'h8000_0000, 1'b1});
        dir_expected.push_back(update_t'{4'd4,  32'hFFDF_0000, 1'b1});
        dir_expected.push_back(update_t'{4'd0,  32'h0000_0000, 1'b0});
        dir_expected.push_back(update_t'{4'd1,  32'h0000_0000, 1'b0});
        dir_expected.push_back(update_t'{4'd2,  32'h0000_0000, 1'b0});
        dir_expected.push_back(update_t'{4'd3,  32'h0000_0000, 1'b1});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side.
        typed_pos = 0;
        foreach (dir_rows[r])
        begin
            send_frame(dir_rows[r].frm);
            if (dir_rows[r].n_typed < 0)
            begin
                predict_updates(dir_rows[r].frm);
            end
            else
            begin
                for (int k = 0; k < dir_rows[r].n_typed; k++)
                begin
                    pending_updates.push_back(dir_expected[typed_pos]);
                    typed_pos++;
                end
            end
        end
        drain_updates();

        // Random part. Each phase ends with the sender holding off until every update of
        // the phase has arrived.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if ($urandom_range(99) < 75)
                begin
                    id = known_ids[$urandom_range(5)];
                end
                else
                begin
                    id = 11'($urandom_range(2047));
                end
                if ($urandom_range(4) == 0)
                begin
                    data = {8{fill_byte[$urandom_range(3)]}};
                end
                else
                begin
                    data = {$urandom, $urandom};
                end
                send_frame(frame_of(id, data));
                predict_updates(frame_of(id, data));
            end
            drain_updates();
        end

        // The bench then runs on with no frames and no receiver stalls, so that any stray
        // update still shows up before the verdict.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3 * NUM_SIGNALS) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS can_signal_extractor");
        end
        else
        begin
            $display("FAIL can_signal_extractor");
        end
        $finish;
    end

endmodule

// ----- can_signal_extractor.f -----
design/cse_pkg.sv
design/cse_scale_unit.sv
design/can_signal_extractor.sv
bench/tb_top.sv
